>>> rtl/qte_pkg.sv
// Shared constants, types and tables for the quaternion to Euler angle pipeline.
package qte_pkg;

  // Iteration counts of the pipelined units
  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS   = 29;
  localparam int DIV_STEPS    = 15;

  // Widths
  localparam int NUM_W = 34;  // atan2 arguments, scale 2^28
  localparam int S_W   = 30;  // clamped asin argument
  localparam int RAD_W = 57;  // 2^56 - s*s
  localparam int C_W   = 29;  // sqrt result
  localparam int X_W   = 37;  // CORDIC vector
  localparam int Z_W   = 28;  // CORDIC angle, scale 2^24
  localparam int MAX_W = 15;

  // Constants
  localparam logic signed [Z_W-1:0]   ANG_PI      = Z_W'(52707179);
  localparam logic signed [NUM_W-1:0] ONE_Q28     = NUM_W'(268435456);
  localparam logic [RAD_W-1:0]        ONE_Q56     = RAD_W'(1) << 56;
  localparam logic signed [16:0]      ANGLE_LIMIT = 17'sd25736;
  localparam logic signed [16:0]      PITCH_LIMIT = 17'sd12868;
  localparam logic [15:0]             FULL_SCALE  = 16'd16384;

  // Register map
  localparam logic [1:0] REG_MAX_YAW   = 2'd0;
  localparam logic [1:0] REG_MAX_PITCH = 2'd1;
  localparam logic [1:0] REG_MAX_ROLL  = 2'd2;

  // atan2 arguments, asin argument
  typedef struct packed {
    logic signed [NUM_W-1:0] yaw_y;
    logic signed [NUM_W-1:0] yaw_x;
    logic signed [NUM_W-1:0] roll_y;
    logic signed [NUM_W-1:0] roll_x;
    logic signed [S_W-1:0]   s;
  } side_t;

  // Angles in Q3.13
  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
  } ang_t;

  // Arctangent table, scale 2^24
  function automatic logic signed [Z_W-1:0] atan_entry(input int i);
    logic signed [Z_W-1:0] r;
    case (i)
      0:  r = Z_W'(13176795);
      1:  r = Z_W'(7778716);
      2:  r = Z_W'(4110060);
      3:  r = Z_W'(2086331);
      4:  r = Z_W'(1047214);
      5:  r = Z_W'(524117);
      6:  r = Z_W'(262123);
      7:  r = Z_W'(131069);
      8:  r = Z_W'(65536);
      9:  r = Z_W'(32768);
      10: r = Z_W'(16384);
      11: r = Z_W'(8192);
      12: r = Z_W'(4096);
      13: r = Z_W'(2048);
      14: r = Z_W'(1024);
      15: r = Z_W'(512);
      16: r = Z_W'(256);
      17: r = Z_W'(128);
      18: r = Z_W'(64);
      19: r = Z_W'(32);
      20: r = Z_W'(16);
      21: r = Z_W'(8);
      22: r = Z_W'(4);
      23: r = Z_W'(2);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/qte_front.sv
// Front end: component products, atan2/asin arguments and the sqrt radicand.
module qte_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [15:0]        cw,
  input  logic signed [15:0]        cx,
  input  logic signed [15:0]        cy,
  input  logic signed [15:0]        cz,
  output logic                      out_valid,
  output qte_pkg::side_t            out_side,
  output logic [qte_pkg::RAD_W-1:0] out_rad
);
  import qte_pkg::*;

  logic [3:0] vld;

  // stage 1 products
  logic signed [31:0] xy, wz, ww, xx, yz, wx, zz, xz, wy;
  // stage 2 sums
  side_t side2;
  side_t side2_next;
  // stage 3 square
  side_t side3;
  logic [RAD_W-1:0] ss3;
  // stage 4 radicand
  side_t side4;
  logic [RAD_W-1:0] rad4;

  logic signed [NUM_W-1:0] s_raw;
  logic signed [2*S_W-1:0] s_sq;

  // argument sums and asin clamp
  always_comb begin
    side2_next.yaw_y  = (NUM_W'(xy) - NUM_W'(wz)) <<< 1;
    side2_next.yaw_x  = ((NUM_W'(ww) + NUM_W'(xx)) <<< 1) - ONE_Q28;
    side2_next.roll_y = (NUM_W'(yz) - NUM_W'(wx)) <<< 1;
    side2_next.roll_x = ((NUM_W'(ww) + NUM_W'(zz)) <<< 1) - ONE_Q28;
    s_raw = (NUM_W'(xz) + NUM_W'(wy)) <<< 1;
    if (s_raw > ONE_Q28) begin
      side2_next.s = S_W'(ONE_Q28);
    end else if (s_raw < -ONE_Q28) begin
      side2_next.s = S_W'(-ONE_Q28);
    end else begin
      side2_next.s = S_W'(s_raw);
    end
  end

  assign s_sq = side2.s * side2.s;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      xy <= cx * cy;
      wz <= cw * cz;
      ww <= cw * cw;
      xx <= cx * cx;
      yz <= cy * cz;
      wx <= cw * cx;
      zz <= cz * cz;
      xz <= cx * cz;
      wy <= cw * cy;
      side2 <= side2_next;
      side3 <= side2;
      ss3   <= s_sq[RAD_W-1:0];
      side4 <= side3;
      rad4  <= ONE_Q56 - ss3;
    end
  end

  assign out_valid = vld[3];
  assign out_side  = side4;
  assign out_rad   = rad4;

endmodule

>>> rtl/qte_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module qte_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  qte_pkg::side_t            in_side,
  input  logic [qte_pkg::RAD_W-1:0] in_rad,
  output logic                      out_valid,
  output qte_pkg::side_t            out_side,
  output logic [qte_pkg::C_W-1:0]   out_c
);
  import qte_pkg::*;

  localparam int SW = RAD_W + 1;

  logic [SW-1:0] rem  [0:SQRT_STEPS-1];
  logic [SW-1:0] res  [0:SQRT_STEPS-1];
  side_t         side [0:SQRT_STEPS-1];
  logic [SQRT_STEPS-1:0] vld;

  logic [SW-1:0] src_rem  [0:SQRT_STEPS-1];
  logic [SW-1:0] src_res  [0:SQRT_STEPS-1];
  logic [SW-1:0] rem_next [0:SQRT_STEPS-1];
  logic [SW-1:0] res_next [0:SQRT_STEPS-1];

  // one digit-pair step per stage, bit weight 4^(SQRT_STEPS-1-k)
  always_comb begin
    logic [SW-1:0] bitk;
    logic [SW-1:0] trial;
    src_rem[0] = SW'(in_rad);
    src_res[0] = '0;
    for (int k = 1; k < SQRT_STEPS; k++) begin
      src_rem[k] = rem[k-1];
      src_res[k] = res[k-1];
    end
    for (int k = 0; k < SQRT_STEPS; k++) begin
      bitk  = SW'(1) << (2 * (SQRT_STEPS - 1 - k));
      trial = src_res[k] + bitk;
      if (src_rem[k] >= trial) begin
        rem_next[k] = src_rem[k] - trial;
        res_next[k] = (src_res[k] >> 1) + bitk;
      end else begin
        rem_next[k] = src_rem[k];
        res_next[k] = src_res[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[SQRT_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        rem[k] <= rem_next[k];
        res[k] <= res_next[k];
      end
      for (int k = 1; k < SQRT_STEPS; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  assign out_valid = vld[SQRT_STEPS-1];
  assign out_side  = side[SQRT_STEPS-1];
  assign out_c     = res[SQRT_STEPS-1][C_W-1:0];

endmodule

>>> rtl/qte_cordic.sv
// Three-lane pipelined vectoring CORDIC (yaw, pitch, roll) with Q3.13 output.
module qte_cordic (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  qte_pkg::side_t          in_side,
  input  logic [qte_pkg::C_W-1:0] in_c,
  output logic                    out_valid,
  output qte_pkg::ang_t           out_ang
);
  import qte_pkg::*;

  localparam int LANES = 3;
  localparam int ST = CORDIC_STEPS + 1;

  // stage 0 is the quadrant fold, stages 1..CORDIC_STEPS the iterations
  logic signed [X_W-1:0] vx [0:ST-1][0:LANES-1];
  logic signed [X_W-1:0] vy [0:ST-1][0:LANES-1];
  logic signed [Z_W-1:0] vz [0:ST-1][0:LANES-1];
  logic                  zf [0:ST-1][0:LANES-1];
  logic [ST:0] vld;
  ang_t ang;

  logic signed [X_W-1:0] ix [0:LANES-1];
  logic signed [X_W-1:0] iy [0:LANES-1];
  logic signed [X_W-1:0] fx_next [0:LANES-1];
  logic signed [X_W-1:0] fy_next [0:LANES-1];
  logic signed [Z_W-1:0] fz_next [0:LANES-1];
  logic                  fzf_next [0:LANES-1];
  logic signed [X_W-1:0] x_next [1:ST-1][0:LANES-1];
  logic signed [X_W-1:0] y_next [1:ST-1][0:LANES-1];
  logic signed [Z_W-1:0] z_next [1:ST-1][0:LANES-1];
  logic signed [16:0] rq [0:LANES-1];
  ang_t ang_next;

  assign ix[0] = X_W'(in_side.yaw_x);
  assign iy[0] = X_W'(in_side.yaw_y);
  assign ix[1] = X_W'($signed({1'b0, in_c}));
  assign iy[1] = X_W'(in_side.s);
  assign ix[2] = X_W'(in_side.roll_x);
  assign iy[2] = X_W'(in_side.roll_y);

  // fold a negative x into the right half plane, plus or minus pi
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      fzf_next[l] = (ix[l] == '0) && (iy[l] == '0);
      if (ix[l] < 0) begin
        fx_next[l] = -ix[l];
        fy_next[l] = -iy[l];
        fz_next[l] = (iy[l] >= 0) ? ANG_PI : -ANG_PI;
      end else begin
        fx_next[l] = ix[l];
        fy_next[l] = iy[l];
        fz_next[l] = '0;
      end
    end
  end

  // one rotation per stage
  always_comb begin
    for (int k = 1; k < ST; k++) begin
      for (int l = 0; l < LANES; l++) begin
        if (vy[k-1][l] >= 0) begin
          x_next[k][l] = vx[k-1][l] + (vy[k-1][l] >>> (k - 1));
          y_next[k][l] = vy[k-1][l] - (vx[k-1][l] >>> (k - 1));
          z_next[k][l] = vz[k-1][l] + atan_entry(k - 1);
        end else begin
          x_next[k][l] = vx[k-1][l] - (vy[k-1][l] >>> (k - 1));
          y_next[k][l] = vy[k-1][l] + (vx[k-1][l] >>> (k - 1));
          z_next[k][l] = vz[k-1][l] - atan_entry(k - 1);
        end
      end
    end
  end

  // round to Q3.13 and clamp
  always_comb begin
    logic signed [Z_W-1:0] a;
    logic signed [16:0] lim;
    for (int l = 0; l < LANES; l++) begin
      a = zf[ST-1][l] ? '0 : vz[ST-1][l];
      lim = (l == 1) ? PITCH_LIMIT : ANGLE_LIMIT;
      rq[l] = 17'((a + Z_W'(1024)) >>> 11);
      if (rq[l] > lim) begin
        rq[l] = lim;
      end else if (rq[l] < -lim) begin
        rq[l] = -lim;
      end
    end
    ang_next.yaw   = rq[0][15:0];
    ang_next.pitch = 15'(-rq[1]);
    ang_next.roll  = rq[2][15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ST-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        vx[0][l] <= fx_next[l];
        vy[0][l] <= fy_next[l];
        vz[0][l] <= fz_next[l];
        zf[0][l] <= fzf_next[l];
        for (int k = 1; k < ST; k++) begin
          vx[k][l] <= x_next[k][l];
          vy[k][l] <= y_next[k][l];
          vz[k][l] <= z_next[k][l];
          zf[k][l] <= zf[k-1][l];
        end
      end
      ang <= ang_next;
    end
  end

  assign out_valid = vld[ST];
  assign out_ang   = ang;

endmodule

>>> rtl/qte_scale.sv
// Three-lane pipelined restoring divider: angle / max, rounded and saturated to Q1.14.
module qte_scale (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  qte_pkg::ang_t             in_ang,
  input  logic [qte_pkg::MAX_W-1:0] max_yaw,
  input  logic [qte_pkg::MAX_W-1:0] max_pitch,
  input  logic [qte_pkg::MAX_W-1:0] max_roll,
  output logic                      out_valid,
  output qte_pkg::ang_t             out_ang,
  output logic signed [15:0]        yaw_scaled,
  output logic signed [15:0]        pitch_scaled,
  output logic signed [15:0]        roll_scaled
);
  import qte_pkg::*;

  localparam int LANES = 3;
  localparam int RW = 32;

  // stage 0 is setup, stages 1..DIV_STEPS one quotient bit each
  logic [RW-1:0]        rem  [0:DIV_STEPS][0:LANES-1];
  logic [MAX_W:0]       dv   [0:DIV_STEPS][0:LANES-1];
  logic [DIV_STEPS-1:0] quo  [0:DIV_STEPS][0:LANES-1];
  logic                 neg  [0:DIV_STEPS][0:LANES-1];
  logic                 nz   [0:DIV_STEPS][0:LANES-1];
  logic                 mz   [0:DIV_STEPS][0:LANES-1];
  logic                 sat  [0:DIV_STEPS][0:LANES-1];
  ang_t                 angs [0:DIV_STEPS];
  logic [DIV_STEPS+1:0] vld;
  ang_t                 ang_out;
  logic signed [15:0]   scl [0:LANES-1];

  logic signed [15:0]   la [0:LANES-1];
  logic [MAX_W-1:0]     lm [0:LANES-1];
  logic [RW-1:0]        rem0_next [0:LANES-1];
  logic [MAX_W:0]       dv0_next  [0:LANES-1];
  logic                 sat0_next [0:LANES-1];
  logic [RW-1:0]        rem_next [1:DIV_STEPS][0:LANES-1];
  logic [DIV_STEPS-1:0] quo_next [1:DIV_STEPS][0:LANES-1];
  logic signed [15:0]   scl_next [0:LANES-1];

  assign la[0] = in_ang.yaw;
  assign la[1] = 16'(in_ang.pitch);
  assign la[2] = in_ang.roll;
  assign lm[0] = max_yaw;
  assign lm[1] = max_pitch;
  assign lm[2] = max_roll;

  // numerator mag*32768 + m over divisor 2m; overflow past 15 quotient bits saturates
  always_comb begin
    logic [MAX_W-1:0] mag;
    for (int l = 0; l < LANES; l++) begin
      mag = la[l][15] ? MAX_W'(-la[l]) : MAX_W'(la[l]);
      rem0_next[l] = {2'b00, mag, 15'd0} + RW'(lm[l]);
      dv0_next[l]  = {lm[l], 1'b0};
      sat0_next[l] = rem0_next[l] >= (RW'(dv0_next[l]) << DIV_STEPS);
    end
  end

  // restoring division steps
  always_comb begin
    logic [RW-1:0] dsh;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      for (int l = 0; l < LANES; l++) begin
        dsh = RW'(dv[k-1][l]) << (DIV_STEPS - k);
        quo_next[k][l] = quo[k-1][l];
        if (rem[k-1][l] >= dsh) begin
          rem_next[k][l] = rem[k-1][l] - dsh;
          quo_next[k][l][DIV_STEPS-k] = 1'b1;
        end else begin
          rem_next[k][l] = rem[k-1][l];
        end
      end
    end
  end

  // saturate and apply the sign; a zero maximum gives the sign of the angle
  always_comb begin
    logic [15:0] q;
    for (int l = 0; l < LANES; l++) begin
      if (mz[DIV_STEPS][l]) begin
        q = nz[DIV_STEPS][l] ? FULL_SCALE : '0;
      end else if (sat[DIV_STEPS][l] || (16'(quo[DIV_STEPS][l]) > FULL_SCALE)) begin
        q = FULL_SCALE;
      end else begin
        q = 16'(quo[DIV_STEPS][l]);
      end
      scl_next[l] = neg[DIV_STEPS][l] ? -$signed(q) : $signed(q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_STEPS:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angs[0] <= in_ang;
      for (int l = 0; l < LANES; l++) begin
        rem[0][l] <= rem0_next[l];
        dv[0][l]  <= dv0_next[l];
        quo[0][l] <= '0;
        neg[0][l] <= la[l][15];
        nz[0][l]  <= la[l] != '0;
        mz[0][l]  <= lm[l] == '0;
        sat[0][l] <= sat0_next[l];
        for (int k = 1; k <= DIV_STEPS; k++) begin
          rem[k][l] <= rem_next[k][l];
          quo[k][l] <= quo_next[k][l];
          dv[k][l]  <= dv[k-1][l];
          neg[k][l] <= neg[k-1][l];
          nz[k][l]  <= nz[k-1][l];
          mz[k][l]  <= mz[k-1][l];
          sat[k][l] <= sat[k-1][l];
        end
        scl[l] <= scl_next[l];
      end
      for (int k = 1; k <= DIV_STEPS; k++) begin
        angs[k] <= angs[k-1];
      end
      ang_out <= angs[DIV_STEPS];
    end
  end

  assign out_valid    = vld[DIV_STEPS+1];
  assign out_ang      = ang_out;
  assign yaw_scaled   = scl[0];
  assign pitch_scaled = scl[1];
  assign roll_scaled  = scl[2];

endmodule

>>> rtl/quaternion_to_normalized_euler.sv
// Top level: quaternion to yaw/pitch/roll with per-axis normalization.
//
// Input stream (s_*): one quaternion per item, four 32-bit words; only the
// upper 16 bits of each word (Q2.14) are used. Output stream (m_*): one
// result per item: three Q3.13 angles and three Q1.14 normalized angles.
// The APB port holds max_yaw (0x0), max_pitch (0x4), max_roll (0x8); write
// them only while no item is in flight.
//
// The pipeline has 4 front-end stages, 29 square-root stages,
// CORDIC_STEPS + 2 CORDIC stages and 17 divider stages. Throughput is one
// item per cycle while the output is not stalled; every stage is a full register.
//
// The whole pipeline advances together. When the output item is not taken,
// all stages hold and s_tready drops in the same cycle; nothing is lost or
// repeated. Synchronous reset clears all valid bits and the three maximum
// registers to zero.
module quaternion_to_normalized_euler (
  input  logic         clk,
  input  logic         rst,
  // APB configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // quat_w[31:0], quat_x[63:32], quat_y[95:64], quat_z[127:96]
  // output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata   // yaw_angle[15:0], pitch_angle[30:16], roll_angle[46:31],
                                 // yaw_scaled[62:47], pitch_scaled[78:63],
                                 // roll_scaled[94:79], zero[95]
);
  import qte_pkg::*;

  logic [MAX_W-1:0] max_yaw, max_pitch, max_roll;
  logic en;

  logic          fr_valid, sq_valid, co_valid, sc_valid;
  side_t         fr_side, sq_side;
  logic [RAD_W-1:0] fr_rad;
  logic [C_W-1:0]   sq_c;
  ang_t          co_ang, sc_ang;
  logic signed [15:0] yaw_s, pitch_s, roll_s;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_yaw   <= '0;
      max_pitch <= '0;
      max_roll  <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_MAX_YAW:   max_yaw   <= pwdata[MAX_W-1:0];
        REG_MAX_PITCH: max_pitch <= pwdata[MAX_W-1:0];
        REG_MAX_ROLL:  max_roll  <= pwdata[MAX_W-1:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (paddr[3:2])
      REG_MAX_YAW:   prdata = 32'(max_yaw);
      REG_MAX_PITCH: prdata = 32'(max_pitch);
      REG_MAX_ROLL:  prdata = 32'(max_roll);
      default:       prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // global pipeline advance
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  qte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .cw        ($signed(s_tdata[31:16])),
    .cx        ($signed(s_tdata[63:48])),
    .cy        ($signed(s_tdata[95:80])),
    .cz        ($signed(s_tdata[127:112])),
    .out_valid (fr_valid),
    .out_side  (fr_side),
    .out_rad   (fr_rad)
  );

  qte_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .in_side   (fr_side),
    .in_rad    (fr_rad),
    .out_valid (sq_valid),
    .out_side  (sq_side),
    .out_c     (sq_c)
  );

  qte_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .in_side   (sq_side),
    .in_c      (sq_c),
    .out_valid (co_valid),
    .out_ang   (co_ang)
  );

  qte_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (co_valid),
    .in_ang       (co_ang),
    .max_yaw      (max_yaw),
    .max_pitch    (max_pitch),
    .max_roll     (max_roll),
    .out_valid    (sc_valid),
    .out_ang      (sc_ang),
    .yaw_scaled   (yaw_s),
    .pitch_scaled (pitch_s),
    .roll_scaled  (roll_s)
  );

  assign m_tvalid = sc_valid;
  assign m_tdata  = {1'b0, roll_s, pitch_s, yaw_s, sc_ang.roll, sc_ang.pitch, sc_ang.yaw};

  // ready drops only while a result is stalled
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without an output stall");

  // a non-negative yaw never normalizes to a negative value
  a_yaw_sign: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[15]) |-> !m_tdata[62])
    else $error("yaw_scaled negative for a non-negative yaw");

  // a zero roll normalizes to zero
  a_roll_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[46:31] == 16'd0)) |-> (m_tdata[94:79] == 16'd0))
    else $error("roll_scaled nonzero for a zero roll");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule
